// File: hdl/wrp_pkg.sv
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants for the RIFF/WAVE PCM stream parser.
// ----------------------------------------------------------------------------
package wrp_pkg;

    localparam logic [31:0] ID_FMT       = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA      = 32'h6174_6164;
    localparam logic [31:0] ID_RIFF      = 32'h4646_4952;
    localparam logic [31:0] DEFAULT_RATE = 32'd44100;
    localparam logic [15:0] DEFAULT_CH   = 16'd2;
    localparam logic [4:0]  DEPTH_16     = 5'd16;
    localparam logic [4:0]  DEPTH_24     = 5'd24;
    localparam logic [15:0] FMT_PCM      = 16'd1;

    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        EV_SAMPLE = 2'd0,
        EV_FORMAT = 2'd1,
        EV_ERROR  = 2'd2
    } event_t;

    typedef enum logic {
        ERR_FORMAT = 1'b0,
        ERR_DEPTH  = 1'b1
    } err_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_FMT    = 3'd1,
        PH_DATA   = 3'd2,
        PH_SKIP   = 3'd3,
        PH_FORM   = 3'd4,
        PH_ERROR  = 3'd5
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

endpackage

// File: hdl/wav_riff_pcm_parser.sv
// ----------------------------------------------------------------------------
// wav_riff_pcm_parser
// RIFF/WAVE byte stream parser producing signed 16-bit PCM samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per byte; s_kind = 1 restarts the parser for a new
//   stream, s_kind = 0 carries s_data_byte. Items enter a two-entry queue.
//   m_ channel: at most one result per byte: a sample, a format event at each
//   data chunk header, or a single sticky error; format fields ride along on
//   every result.
//   Throughput is one byte per cycle while no result waits on a low m_ready;
//   the parser consumes the queue head and writes the result register in
//   the same cycle; a byte passes the queue register, then the result register.
//   When m_ready is low and a result waits, the parser holds; the queue
//   still takes up to two more bytes before s_ready drops.
//   Reset (aresetn low, synchronous) empties the queue and restores the
//   default format of 44100 Hz, 2 channels, 16 bits.
// ----------------------------------------------------------------------------
module wav_riff_pcm_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [7:0]         s_data_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_event_res,
    output logic signed [15:0] m_sample,
    output logic [15:0]        m_channel_index,
    output logic               m_frame_end,
    output logic [31:0]        m_sample_rate,
    output logic [15:0]        m_channel_count,
    output logic [4:0]         m_bit_depth,
    output logic [31:0]        m_data_length,
    output logic               m_error_code
);
    import wrp_pkg::*;

    item_t      in_item;
    q_head_t    head;
    logic       full;
    logic       pop;
    logic [1:0] q_count;

    assign in_item.kind      = s_kind;
    assign in_item.data_byte = s_data_byte;
    assign s_ready           = !full;

    wrp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && !full),
        .push_item (in_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .count     (q_count)
    );

    wrp_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (head),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_sample        (m_sample),
        .m_channel_index (m_channel_index),
        .m_frame_end     (m_frame_end),
        .m_sample_rate   (m_sample_rate),
        .m_channel_count (m_channel_count),
        .m_bit_depth     (m_bit_depth),
        .m_data_length   (m_data_length),
        .m_error_code    (m_error_code)
    );

    a_qcount: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= 2'(QDEPTH))
        else $error("queue count overflow");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("pop from empty queue");

    a_event_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res != EV_SAMPLE) |->
        (m_sample == 16'sd0 && m_channel_index == 16'd0 && !m_frame_end))
        else $error("event result carries sample fields");

    a_event_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_res != 2'd3))
        else $error("bad event code");

endmodule

// File: hdl/wrp_queue.sv
// ----------------------------------------------------------------------------
// wrp_queue
// Front end: accepts items into a two-entry queue ahead of the parser.
// ----------------------------------------------------------------------------
module wrp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wrp_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output wrp_pkg::q_head_t head,
    output logic [1:0]      count
);
    import wrp_pkg::*;

    item_t      mem_reg [QDEPTH];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'(QDEPTH));
    assign count      = count_reg;
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = mem_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = ~wptr_reg;
        end
        if (pop) begin
            rptr_next = ~rptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/wrp_parser.sv
// ----------------------------------------------------------------------------
// wrp_parser
// Back end: walks chunk headers, captures fmt, slices data into samples,
// and holds each result in an output register.
// ----------------------------------------------------------------------------
module wrp_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  wrp_pkg::q_head_t head,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_event_res,
    output logic signed [15:0] m_sample,
    output logic [15:0]      m_channel_index,
    output logic             m_frame_end,
    output logic [31:0]      m_sample_rate,
    output logic [15:0]      m_channel_count,
    output logic [4:0]       m_bit_depth,
    output logic [31:0]      m_data_length,
    output logic             m_error_code
);
    import wrp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bcnt_reg, bcnt_next;
    logic [63:0] hs_reg, hs_next;
    logic [31:0] rem_reg, rem_next;
    logic        havefmt_reg, havefmt_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] chans_reg, chans_next;
    logic [4:0]  depth_reg, depth_next;
    logic [15:0] afmt_reg, afmt_next;
    logic [15:0] sbytes_reg, sbytes_next;
    logic [1:0]  sidx_reg, sidx_next;
    logic [15:0] chcnt_reg, chcnt_next;
    logic [31:0] total_reg, total_next;

    logic        mvalid_reg;
    logic [1:0]  ev_reg, ev_next;
    logic [15:0] smp_reg, smp_next;
    logic [15:0] chi_reg, chi_next;
    logic        fend_reg, fend_next;
    logic        err_reg, err_next;
    logic        emit;

    logic [63:0] hs_in;
    logic [31:0] id, len;
    logic [15:0] bits;
    logic [1:0]  bps;
    logic [17:0] frame_size;
    logic [16:0] ch_inc;
    logic        fend;
    logic        take;
    logic [7:0]  b;

    // advance when a result slot is free or being drained
    assign take = head.valid && (!mvalid_reg || m_ready);
    assign pop  = take;
    assign b    = head.item.data_byte;

    always_comb begin
        hs_in       = hs_reg | (64'(b) << {bcnt_reg[2:0], 3'b000});
        id          = hs_in[31:0];
        len         = hs_in[63:32];
        bits        = {b, sbytes_reg[7:0]};
        bps         = (depth_reg == DEPTH_24) ? 2'd3 : 2'd2;
        frame_size  = (bps == 2'd3) ? (18'(chans_reg) + {1'b0, chans_reg, 1'b0})
                                    : {1'b0, chans_reg, 1'b0};
        ch_inc      = 17'(chcnt_reg) + 17'd1;
        fend        = (ch_inc >= 17'(chans_reg));
    end

    always_comb begin
        phase_next   = phase_reg;
        bcnt_next    = bcnt_reg;
        hs_next      = hs_reg;
        rem_next     = rem_reg;
        havefmt_next = havefmt_reg;
        rate_next    = rate_reg;
        chans_next   = chans_reg;
        depth_next   = depth_reg;
        afmt_next    = afmt_reg;
        sbytes_next  = sbytes_reg;
        sidx_next    = sidx_reg;
        chcnt_next   = chcnt_reg;
        total_next   = total_reg;
        emit         = 1'b0;
        ev_next      = EV_SAMPLE;
        smp_next     = 16'd0;
        chi_next     = 16'd0;
        fend_next    = 1'b0;
        err_next     = ERR_FORMAT;

        if (take && head.item.kind) begin
            phase_next   = PH_HEADER;
            bcnt_next    = 4'd0;
            hs_next      = 64'd0;
            rem_next     = 32'd0;
            havefmt_next = 1'b0;
            rate_next    = DEFAULT_RATE;
            chans_next   = DEFAULT_CH;
            depth_next   = DEPTH_16;
            afmt_next    = 16'd0;
            sbytes_next  = 16'd0;
            sidx_next    = 2'd0;
            chcnt_next   = 16'd0;
            total_next   = 32'd0;
        end else if (take) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (bcnt_reg[2:0] != 3'd7) begin
                        hs_next   = hs_in;
                        bcnt_next = bcnt_reg + 4'd1;
                    end else begin
                        bcnt_next = 4'd0;
                        hs_next   = 64'd0;
                        if (id == ID_RIFF) begin
                            phase_next = PH_FORM;
                        end else begin
                            rem_next = len;
                            if (id == ID_FMT) begin
                                havefmt_next = 1'b0;
                                phase_next   = PH_FMT;
                            end else if (id == ID_DATA) begin
                                total_next = len;
                                if (!havefmt_reg) begin
                                    rate_next  = DEFAULT_RATE;
                                    chans_next = DEFAULT_CH;
                                    depth_next = DEPTH_16;
                                end
                                sbytes_next = 16'd0;
                                sidx_next   = 2'd0;
                                chcnt_next  = 16'd0;
                                phase_next  = (len == 32'd0) ? PH_HEADER : PH_DATA;
                                emit        = 1'b1;
                                ev_next     = EV_FORMAT;
                            end else begin
                                phase_next = (len == 32'd0) ? PH_HEADER : PH_SKIP;
                            end
                        end
                    end
                end
                PH_FORM: begin
                    if (bcnt_reg >= 4'd3) begin
                        bcnt_next  = 4'd0;
                        phase_next = PH_HEADER;
                    end else begin
                        bcnt_next = bcnt_reg + 4'd1;
                    end
                end
                PH_FMT: begin
                    if (bcnt_reg < 4'd8) begin
                        hs_next = hs_in;
                    end else if (bcnt_reg == 4'd14) begin
                        sbytes_next = 16'(b);
                    end
                    if (bcnt_reg != 4'd15) begin
                        bcnt_next = bcnt_reg + 4'd1;
                    end else begin
                        bcnt_next   = 4'd0;
                        hs_next     = 64'd0;
                        sbytes_next = 16'd0;
                        afmt_next   = hs_reg[15:0];
                        if (hs_reg[15:0] != FMT_PCM) begin
                            phase_next = PH_ERROR;
                            emit       = 1'b1;
                            ev_next    = EV_ERROR;
                            err_next   = ERR_FORMAT;
                        end else if (bits != 16'(DEPTH_16) && bits != 16'(DEPTH_24)) begin
                            phase_next = PH_ERROR;
                            emit       = 1'b1;
                            ev_next    = EV_ERROR;
                            err_next   = ERR_DEPTH;
                        end else begin
                            rate_next    = hs_reg[63:32];
                            chans_next   = (hs_reg[31:16] != 16'd0) ? hs_reg[31:16]
                                                                    : DEFAULT_CH;
                            depth_next   = bits[4:0];
                            havefmt_next = 1'b1;
                            rem_next     = (rem_reg > 32'd16) ? rem_reg - 32'd16 : 32'd0;
                            phase_next   = (rem_next == 32'd0) ? PH_HEADER : PH_SKIP;
                        end
                    end
                end
                PH_DATA: begin
                    rem_next = rem_reg - 32'd1;
                    if (sidx_reg == 2'd0 && chcnt_reg == 16'd0 &&
                        rem_reg < 32'(frame_size)) begin
                        // drop a trailing partial frame
                        phase_next = (rem_next == 32'd0) ? PH_HEADER : PH_SKIP;
                    end else begin
                        sbytes_next = {b, sbytes_reg[15:8]};
                        sidx_next   = sidx_reg + 2'd1;
                        if (sidx_next >= bps) begin
                            emit       = 1'b1;
                            ev_next    = EV_SAMPLE;
                            smp_next   = sbytes_next;
                            chi_next   = chcnt_reg;
                            fend_next  = fend;
                            sidx_next  = 2'd0;
                            chcnt_next = fend ? 16'd0 : ch_inc[15:0];
                        end
                        if (rem_next == 32'd0) begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                PH_SKIP: begin
                    if (rem_reg != 32'd0) begin
                        rem_next = rem_reg - 32'd1;
                    end
                    if (rem_next == 32'd0) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_ERROR: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            bcnt_reg    <= 4'd0;
            hs_reg      <= 64'd0;
            rem_reg     <= 32'd0;
            havefmt_reg <= 1'b0;
            rate_reg    <= DEFAULT_RATE;
            chans_reg   <= DEFAULT_CH;
            depth_reg   <= DEPTH_16;
            afmt_reg    <= 16'd0;
            sbytes_reg  <= 16'd0;
            sidx_reg    <= 2'd0;
            chcnt_reg   <= 16'd0;
            total_reg   <= 32'd0;
            mvalid_reg  <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            bcnt_reg    <= bcnt_next;
            hs_reg      <= hs_next;
            rem_reg     <= rem_next;
            havefmt_reg <= havefmt_next;
            rate_reg    <= rate_next;
            chans_reg   <= chans_next;
            depth_reg   <= depth_next;
            afmt_reg    <= afmt_next;
            sbytes_reg  <= sbytes_next;
            sidx_reg    <= sidx_next;
            chcnt_reg   <= chcnt_next;
            total_reg   <= total_next;
            if (take) begin
                mvalid_reg <= emit;
            end else if (m_ready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    logic [31:0] orate_reg, ototal_reg;
    logic [15:0] ochans_reg;
    logic [4:0]  odepth_reg;

    always_ff @(posedge aclk) begin
        if (take && emit) begin
            ev_reg     <= ev_next;
            smp_reg    <= smp_next;
            chi_reg    <= chi_next;
            fend_reg   <= fend_next;
            err_reg    <= err_next;
            orate_reg  <= rate_next;
            ochans_reg <= chans_next;
            odepth_reg <= depth_next;
            ototal_reg <= total_next;
        end
    end

    assign m_valid         = mvalid_reg;
    assign m_event_res     = ev_reg;
    assign m_sample        = smp_reg;
    assign m_channel_index = chi_reg;
    assign m_frame_end     = fend_reg;
    assign m_sample_rate   = orate_reg;
    assign m_channel_count = ochans_reg;
    assign m_bit_depth     = odepth_reg;
    assign m_data_length   = ototal_reg;
    assign m_error_code    = err_reg;

endmodule

// File: tb/wav_riff_pcm_parser_tb.sv
// ----------------------------------------------------------------------------
// wav_riff_pcm_parser_tb
// Self-checking bench for the WAV byte stream parser: a directed table of
// bytes and restarts, then random WAV streams, checked against a parser
// model kept in the bench.
// ----------------------------------------------------------------------------
module wav_riff_pcm_parser_tb;
    import wrp_pkg::*;

    typedef struct packed {
        logic [1:0]  ev;
        logic [15:0] smp;
        logic [15:0] ch;
        logic        fend;
        logic [31:0] rate;
        logic [15:0] chans;
        logic [4:0]  depth;
        logic [31:0] dlen;
        logic        err;
    } parse_res_t;

    typedef struct {
        logic       kind;
        logic [7:0] dbyte;
        logic       typed;
        parse_res_t res;
    } vec_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_kind;
    logic [7:0]         s_data_byte;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_event_res;
    logic signed [15:0] m_sample;
    logic [15:0]        m_channel_index;
    logic               m_frame_end;
    logic [31:0]        m_sample_rate;
    logic [15:0]        m_channel_count;
    logic [4:0]         m_bit_depth;
    logic [31:0]        m_data_length;
    logic               m_error_code;

    wav_riff_pcm_parser u_top (.*);

    // parser model state
    phase_t      ph;
    logic [3:0]  bcnt;
    logic [63:0] hshift;
    logic [31:0] remain;
    logic        fmt_ok;
    logic [31:0] rate_q;
    logic [15:0] chans_q;
    logic [4:0]  depth_q;
    logic [15:0] sbytes;
    logic [1:0]  sidx;
    logic [15:0] chcnt;
    logic [31:0] dtotal;

    parse_res_t  pending_res[$];
    logic [7:0]  stream_bytes[$];
    vec_t        dir_vecs[$];
    int          errors;
    int          idle_cycles = 0;
    int          rx_hold;

    function automatic parse_res_t make_res(logic [1:0] ev, logic [15:0] smp,
                                            logic [15:0] ch, logic fend, logic err);
        parse_res_t r;
        r.ev = ev; r.smp = smp; r.ch = ch; r.fend = fend;
        r.rate = rate_q; r.chans = chans_q; r.depth = depth_q;
        r.dlen = dtotal; r.err = err;
        return r;
    endfunction

    function automatic void parser_reset();
        ph = PH_HEADER; bcnt = 4'd0; hshift = 64'd0; remain = 32'd0; fmt_ok = 1'b0;
        rate_q = DEFAULT_RATE; chans_q = DEFAULT_CH; depth_q = DEPTH_16;
        sbytes = 16'd0; sidx = 2'd0; chcnt = 16'd0; dtotal = 32'd0;
    endfunction

    // advance the model by one item; return 1 with the result if one is made
    function automatic bit parse_byte(logic kind, logic [7:0] b, output parse_res_t r);
        logic [31:0] id, len, rate, bps;
        logic [15:0] fmt, ch, bits;
        logic        fe;
        r = '0;
        if (kind) begin
            parser_reset();
            return 0;
        end
        case (ph)
            PH_HEADER: begin
                hshift |= 64'(b) << (8 * bcnt[2:0]);
                if (bcnt[2:0] != 3'd7) begin
                    bcnt = bcnt + 4'd1;
                    return 0;
                end
                id = hshift[31:0]; len = hshift[63:32];
                bcnt = 4'd0; hshift = 64'd0;
                if (id == ID_RIFF) begin
                    ph = PH_FORM;
                    return 0;
                end
                remain = len;
                if (id == ID_FMT) begin
                    fmt_ok = 1'b0; ph = PH_FMT;
                    return 0;
                end
                if (id == ID_DATA) begin
                    dtotal = len;
                    if (!fmt_ok) begin
                        rate_q = DEFAULT_RATE; chans_q = DEFAULT_CH; depth_q = DEPTH_16;
                    end
                    sbytes = 16'd0; sidx = 2'd0; chcnt = 16'd0;
                    ph = (len == 0) ? PH_HEADER : PH_DATA;
                    r = make_res(EV_FORMAT, 16'd0, 16'd0, 1'b0, 1'b0);
                    return 1;
                end
                ph = (remain == 0) ? PH_HEADER : PH_SKIP;
                return 0;
            end
            PH_FORM: begin
                if (bcnt >= 4'd3) begin
                    bcnt = 4'd0; ph = PH_HEADER;
                end else bcnt = bcnt + 4'd1;
                return 0;
            end
            PH_FMT: begin
                if (bcnt < 4'd8) hshift |= 64'(b) << (8 * bcnt);
                else if (bcnt == 4'd14) sbytes = 16'(b);
                if (bcnt != 4'd15) begin
                    bcnt = bcnt + 4'd1;
                    return 0;
                end
                fmt = hshift[15:0]; ch = hshift[31:16]; rate = hshift[63:32];
                bits = {b, sbytes[7:0]};
                bcnt = 4'd0; hshift = 64'd0; sbytes = 16'd0;
                if (fmt != FMT_PCM) begin
                    ph = PH_ERROR;
                    r = make_res(EV_ERROR, 16'd0, 16'd0, 1'b0, ERR_FORMAT);
                    return 1;
                end
                if (bits != 16'(DEPTH_16) && bits != 16'(DEPTH_24)) begin
                    ph = PH_ERROR;
                    r = make_res(EV_ERROR, 16'd0, 16'd0, 1'b0, ERR_DEPTH);
                    return 1;
                end
                rate_q = rate; chans_q = (ch != 16'd0) ? ch : DEFAULT_CH;
                depth_q = bits[4:0]; fmt_ok = 1'b1;
                remain = (remain > 32'd16) ? remain - 32'd16 : 32'd0;
                ph = (remain == 0) ? PH_HEADER : PH_SKIP;
                return 0;
            end
            PH_DATA: begin
                bps = (depth_q == DEPTH_24) ? 32'd3 : 32'd2;
                // drop a trailing partial frame
                if (sidx == 2'd0 && chcnt == 16'd0 && remain < 32'(chans_q) * bps) begin
                    remain = remain - 32'd1;
                    ph = (remain == 0) ? PH_HEADER : PH_SKIP;
                    return 0;
                end
                sbytes = {b, sbytes[15:8]};
                sidx = sidx + 2'd1;
                remain = remain - 32'd1;
                if (32'(sidx) >= bps) begin
                    fe = (32'(chcnt) + 32'd1 >= 32'(chans_q));
                    r = make_res(EV_SAMPLE, sbytes, chcnt, fe, 1'b0);
                    sidx = 2'd0;
                    chcnt = fe ? 16'd0 : chcnt + 16'd1;
                    if (remain == 0) ph = PH_HEADER;
                    return 1;
                end
                if (remain == 0) ph = PH_HEADER;
                return 0;
            end
            PH_SKIP: begin
                if (remain != 0) remain = remain - 32'd1;
                if (remain == 0) ph = PH_HEADER;
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    task automatic push32(logic [31:0] v);
        for (int i = 0; i < 4; i++) stream_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic push_chunk_hdr(logic [31:0] id, logic [31:0] len);
        push32(id);
        push32(len);
    endtask

    // build one random WAV stream into stream_bytes
    task automatic build_stream();
        int          nch, dep, fmt_len, nfr, dlen, ulen;
        logic [15:0] afmt, bits;
        if ($urandom_range(0, 3) != 0) begin
            push_chunk_hdr(ID_RIFF, $urandom);
            push32($urandom);
        end
        if ($urandom_range(0, 2) == 0) begin
            // unknown chunk with a short body to skip
            ulen = $urandom_range(0, 6);
            push_chunk_hdr($urandom, ulen);
            repeat (ulen) stream_bytes.push_back(8'($urandom));
        end
        nch = $urandom_range(0, 3);
        dep = $urandom_range(0, 1) ? 24 : 16;
        afmt = FMT_PCM;
        bits = 16'(dep);
        case ($urandom_range(0, 19))
            0: afmt = 16'($urandom);
            1: bits = 16'($urandom);
            2: bits = 16'hFFFF;
            default: ;
        endcase
        if ($urandom_range(0, 5) != 0) begin
            fmt_len = $urandom_range(0, 7) == 0 ? $urandom_range(0, 15) : 16 + $urandom_range(0, 4);
            push_chunk_hdr(ID_FMT, fmt_len);
            stream_bytes.push_back(afmt[7:0]); stream_bytes.push_back(afmt[15:8]);
            stream_bytes.push_back(8'(nch)); stream_bytes.push_back(8'(nch >> 8));
            push32($urandom_range(0, 1) ? $urandom : 48000);
            push32($urandom);
            stream_bytes.push_back(8'($urandom)); stream_bytes.push_back(8'($urandom));
            stream_bytes.push_back(bits[7:0]); stream_bytes.push_back(bits[15:8]);
            repeat ((fmt_len > 16) ? fmt_len - 16 : 0) stream_bytes.push_back(8'($urandom));
        end
        nfr = $urandom_range(0, 6);
        dlen = nfr * (nch == 0 ? 2 : nch) * (dep == 24 ? 3 : 2) + $urandom_range(0, 2);
        push_chunk_hdr(ID_DATA, dlen);
        repeat (dlen) stream_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 3) == 0) push_chunk_hdr(ID_DATA, 0);
    endtask

    // sender: hand one item over and feed the model at acceptance
    task automatic send_item(logic kind, logic [7:0] b);
        parse_res_t r;
        if ($urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
                @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_data_byte <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (parse_byte(kind, b, r)) pending_res.push_back(r);
    endtask

    // stop offering items
    task automatic idle_input();
        s_valid <= 1'b0;
    endtask

    task automatic add_vec(logic kind, logic [7:0] b);
        vec_t v;
        v.kind = kind; v.dbyte = b; v.typed = 0; v.res = '0;
        dir_vecs.push_back(v);
    endtask

    task automatic add_vec32(logic [31:0] w);
        for (int i = 0; i < 4; i++) add_vec(0, w[8*i +: 8]);
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        m_ready = 1'b0;
        rx_hold = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                rx_hold = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40)
                                                        : $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        parse_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_res.size() == 0) begin
                $error("result with none expected: event %0d", m_event_res);
                errors++;
            end else begin
                e = pending_res.pop_front();
                if (m_event_res != e.ev) begin
                    $error("event_res exp %0d got %0d", e.ev, m_event_res); errors++; end
                if (m_sample != e.smp) begin
                    $error("sample exp %0d got %0d", e.smp, m_sample); errors++; end
                if (m_channel_index != e.ch) begin
                    $error("channel_index exp %0d got %0d", e.ch, m_channel_index); errors++; end
                if (m_frame_end != e.fend) begin
                    $error("frame_end exp %0d got %0d", e.fend, m_frame_end); errors++; end
                if (m_sample_rate != e.rate) begin
                    $error("sample_rate exp %0d got %0d", e.rate, m_sample_rate); errors++; end
                if (m_channel_count != e.chans) begin
                    $error("channel_count exp %0d got %0d", e.chans, m_channel_count); errors++; end
                if (m_bit_depth != e.depth) begin
                    $error("bit_depth exp %0d got %0d", e.depth, m_bit_depth); errors++; end
                if (m_data_length != e.dlen) begin
                    $error("data_length exp %0d got %0d", e.dlen, m_data_length); errors++; end
                if (m_error_code != e.err) begin
                    $error("error_code exp %0d got %0d", e.err, m_error_code); errors++; end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("wav_riff_pcm_parser regression: fail");
            $finish;
        end
    end

    initial begin
        int         sent, n;
        vec_t       v;
        errors = 0;
        aresetn = 1'b0; s_valid = 1'b0; s_kind = 1'b0; s_data_byte = 8'h00;
        parser_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: data before fmt, zero-length data, RIFF container,
        // zero channels, 24-bit truncation, split frame, trailing partial,
        // short fmt, skipped chunk, bad format, restart
        add_vec32(ID_DATA); add_vec32(32'd0);
        v = dir_vecs[$]; v.typed = 1;
        v.res = '{EV_FORMAT, 16'd0, 16'd0, 1'b0, DEFAULT_RATE, DEFAULT_CH, DEPTH_16,
                  32'd0, 1'b0};
        dir_vecs[$] = v;
        add_vec(1, 8'hFF);
        add_vec32(ID_RIFF); add_vec32(32'hFFFF_FFFF); add_vec32(32'h4556_4157);
        add_vec32(32'h1234_5678); add_vec32(32'd1); add_vec(0, 8'hAA);
        add_vec32(ID_FMT); add_vec32(32'd16);
        add_vec(0, 8'h01); add_vec(0, 8'h00); add_vec(0, 8'h00); add_vec(0, 8'h00);
        add_vec32(32'hFFFF_FFFF); add_vec32(32'd0);
        add_vec(0, 8'h00); add_vec(0, 8'h00); add_vec(0, 8'd24); add_vec(0, 8'h00);
        add_vec32(ID_DATA); add_vec32(32'd14);
        for (int i = 0; i < 14; i++) add_vec(0, (i % 2) ? 8'h80 : 8'h7F);
        add_vec(1, 8'h00);
        add_vec32(ID_FMT); add_vec32(32'd4);
        add_vec32(32'h0001_0002); add_vec32(32'd1); add_vec32(32'd0); add_vec32(32'h0011_0000);
        add_vec(0, 8'h55);
        add_vec(1, 8'h00);
        add_vec32(ID_FMT); add_vec32(32'd16);
        add_vec32(32'h0001_FFFE); add_vec32(32'd8000); add_vec32(32'd0); add_vec32(32'h0010_0000);
        add_vec(0, 8'h00);

        foreach (dir_vecs[i]) begin
            n = pending_res.size();
            send_item(dir_vecs[i].kind, dir_vecs[i].dbyte);
            if (dir_vecs[i].typed && pending_res.size() > n)
                pending_res[$] = dir_vecs[i].res;
        end
        send_item(1, 8'h00);
        idle_input();
        @(posedge aclk);

        // long receiver hold-off with the sender still offering
        wait (m_ready == 1'b1);
        rx_hold = 60;
        sent = 0;
        while (sent < 570) begin
            if (stream_bytes.size() == 0) begin
                if ($urandom_range(0, 3) == 0) send_item(1, 8'($urandom));
                build_stream();
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 4)) stream_bytes.push_back(8'($urandom));
            end
            send_item(0, stream_bytes.pop_front());
            sent++;
            if (sent == 280) begin
                // drain before resuming
                idle_input();
                while (pending_res.size() != 0) @(posedge aclk);
                repeat (4) @(posedge aclk);
            end
        end
        idle_input();
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_res.size() == 0)
            $display("wav_riff_pcm_parser regression: pass");
        else
            $display("wav_riff_pcm_parser regression: fail");
        $finish;
    end
endmodule

// File: wav_riff_pcm_parser.f
hdl/wrp_pkg.sv
hdl/wrp_queue.sv
hdl/wrp_parser.sv
hdl/wav_riff_pcm_parser.sv
tb/wav_riff_pcm_parser_tb.sv
